FILE: src/periodic_spline_path_sampler_core_defines.svh
// Assertion macros used by the core RTL file.
`ifndef PERIODIC_SPLINE_PATH_SAMPLER_CORE_DEFINES_SVH
`define PERIODIC_SPLINE_PATH_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pss_pkg.sv
`default_nettype none

package pss_pkg;

    localparam int MAX_POINTS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int PW   = 24;   // position width
    localparam int TW   = 20;   // point time width
    localparam int FW   = 12;   // frame / period width
    localparam int IDW  = 16;   // path id width

    // ratio r: RATIO_BITS fraction bits, clamped to +-2^LIM_LOG2
    localparam int RATIO_BITS = 16;
    localparam int LIM_LOG2   = 3;
    localparam int QB         = RATIO_BITS + LIM_LOG2;
    localparam int RW         = QB + 2;

    localparam int SW = TW + 3;   // divider operands, signed
    localparam int VW = 42;       // de Casteljau intermediates, signed
    localparam int MW = 31;       // multiplier operand width, signed

    typedef struct packed {
        logic [TW-1:0]        t;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] x;
    } pss_point_t;

    // One axis of a matched segment; p0/p3 are raw neighbors.
    typedef struct packed {
        logic signed [PW-1:0] p0;
        logic signed [PW-1:0] p1;
        logic signed [PW-1:0] p2;
        logic signed [PW-1:0] p3;
        logic                 first;
        logic                 last;
    } pss_axis_in_t;

endpackage

`default_nettype wire

FILE: src/pss_point_mem.sv
`default_nettype none

module pss_point_mem
    import pss_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pss_point_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pss_point_t        rd_data
);

    pss_point_t mem [MAX_POINTS];
    pss_point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/pss_div.sv
`default_nettype none

// Signed ratio (num << RATIO_BITS) / den, truncated toward zero and
// clamped to +-2^QB. Restoring, one quotient bit per cycle.
module pss_div
    import pss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [SW-1:0] num,
    input  logic signed [SW-1:0] den,
    output logic                 q_valid,
    output logic signed [RW-1:0] quot
);

    localparam int CW = $clog2(QB + 1);

    logic              busy_reg;
    logic              valid_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SW-1:0]     rem_reg;
    logic [QB-1:0]     sh_reg;
    logic [QB-1:0]     q_reg;
    logic              neg_reg;
    logic [SW-2:0]     dn_reg;
    logic signed [RW-1:0] quot_reg;

    logic [SW-2:0] an_c;
    logic [SW-2:0] dn_c;
    logic          sat_c;
    logic [SW-1:0] rem2_c;
    logic          qbit_c;
    logic [QB-1:0] qmag_c;

    always_comb
    begin
        an_c   = num[SW-1] ? (SW-1)'(-num) : (SW-1)'(num);
        dn_c   = den[SW-1] ? (SW-1)'(-den) : (SW-1)'(den);
        sat_c  = {{LIM_LOG2{1'b0}}, an_c} >= {dn_c, {LIM_LOG2{1'b0}}};
        rem2_c = {rem_reg[SW-2:0], sh_reg[QB-1]};
        qbit_c = rem2_c >= SW'(dn_reg);
        qmag_c = {q_reg[QB-2:0], qbit_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= !sat_c;
            valid_reg <= sat_c;
            cnt_reg   <= CW'(QB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[SW-1] ^ den[SW-1];
            dn_reg  <= dn_c;
            rem_reg <= SW'(an_c >> LIM_LOG2);
            sh_reg  <= {an_c[LIM_LOG2-1:0], {RATIO_BITS{1'b0}}};
            q_reg   <= '0;
            if (sat_c)
            begin
                quot_reg <= (num[SW-1] ^ den[SW-1]) ? -(RW'(1) <<< QB) : (RW'(1) <<< QB);
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit_c ? rem2_c - SW'(dn_reg) : rem2_c;
            sh_reg  <= sh_reg << 1;
            q_reg   <= qmag_c;
            if (cnt_reg == CW'(1))
            begin
                quot_reg <= neg_reg ? -$signed(RW'(qmag_c)) : $signed(RW'(qmag_c));
            end
        end
    end

    assign q_valid = valid_reg;
    assign quot    = quot_reg;

endmodule

`default_nettype wire

FILE: src/pss_axis.sv
`default_nettype none

// One axis: Catmull-Rom inner points, then de Casteljau with one shared
// multiplier (two partial products per lerp).
module pss_axis
    import pss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pss_axis_in_t         seg,
    input  logic                 r_valid,
    input  logic signed [RW-1:0] r,
    output logic                 done,
    output logic signed [PW-1:0] pos
);

    localparam int DW   = PW + 3;
    localparam int MAGW = DW + 1;
    localparam int AW   = 2 * MW;
    localparam int LO_W = 20;
    localparam logic signed [MW-1:0] RECIP6 = MW'(715827882);  // floor(2^32 / 6)
    localparam logic signed [AW-1:0] ROUND  = AW'(64'd1 << (RATIO_BITS - 1));
    localparam logic signed [VW-1:0] POS_MAX = VW'((64'd1 << (PW - 1)) - 64'd1);
    localparam logic signed [VW-1:0] POS_MIN = -VW'(64'd1 << (PW - 1));

    typedef enum logic [9:0] {
        A_IDLE = 10'b0000000001,
        A_MUL1 = 10'b0000000010,
        A_FIX1 = 10'b0000000100,
        A_FIX2 = 10'b0000001000,
        A_WAIT = 10'b0000010000,
        A_DIFF = 10'b0000100000,
        A_MLO  = 10'b0001000000,
        A_MHI  = 10'b0010000000,
        A_SUM  = 10'b0100000000,
        A_WB   = 10'b1000000000
    } ax_state_t;

    ax_state_t st_reg, st_next;
    logic [1:0] lvl_reg;
    logic [1:0] j_reg;
    logic       done_reg;

    logic [MAGW-1:0]      m1_reg, m2_reg;
    logic                 s1_reg, s2_reg;
    logic signed [VW-1:0] v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [VW-1:0] diff_reg;
    logic signed [AW-1:0] prod_reg, acc_reg;
    logic signed [PW-1:0] pos_reg;

    logic signed [DW-1:0] d1_c, d2_c, chord_c;
    logic signed [MW-1:0] mul_a_c, mul_b_c;
    logic [MAGW-1:0]      fm_c, q_c, qf_c;
    logic                 fs_c;
    logic [MAGW+2:0]      rem_c;
    logic signed [VW-1:0] sx_c, a_sel_c, b_sel_c, lerp_c;

    always_comb
    begin
        // mirrored neighbors reduce to twice the chord
        chord_c = (DW'(seg.p2) - DW'(seg.p1)) <<< 1;
        d1_c    = seg.first ? chord_c : DW'(seg.p2) - DW'(seg.p0);
        d2_c    = seg.last  ? chord_c : DW'(seg.p3) - DW'(seg.p1);

        fm_c  = st_reg == A_FIX1 ? m1_reg : m2_reg;
        fs_c  = st_reg == A_FIX1 ? s1_reg : s2_reg;
        q_c   = prod_reg[32 +: MAGW];
        rem_c = (MAGW+3)'(fm_c) - ((MAGW+3)'(q_c) << 2) - ((MAGW+3)'(q_c) << 1);
        qf_c  = (rem_c >= (MAGW+3)'(6)) ? q_c + MAGW'(1) : q_c;
        sx_c  = fs_c ? -$signed(VW'(qf_c)) : $signed(VW'(qf_c));

        case (j_reg)
            2'd0:    begin a_sel_c = v0_reg; b_sel_c = v1_reg; end
            2'd1:    begin a_sel_c = v1_reg; b_sel_c = v2_reg; end
            default: begin a_sel_c = v2_reg; b_sel_c = v3_reg; end
        endcase
        lerp_c = a_sel_c + VW'(acc_reg >>> RATIO_BITS);

        mul_b_c = MW'(r);
        case (st_reg)
            A_MUL1:  begin mul_a_c = $signed(MW'(m1_reg)); mul_b_c = RECIP6; end
            A_FIX1:  begin mul_a_c = $signed(MW'(m2_reg)); mul_b_c = RECIP6; end
            A_MLO:   mul_a_c = $signed(MW'(diff_reg[LO_W-1:0]));
            default: mul_a_c = MW'($signed(diff_reg[VW-1:LO_W]));
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            A_IDLE: if (start) st_next = A_MUL1;
            A_MUL1: st_next = A_FIX1;
            A_FIX1: st_next = A_FIX2;
            A_FIX2: st_next = A_WAIT;
            A_WAIT: if (r_valid) st_next = A_DIFF;
            A_DIFF: st_next = A_MLO;
            A_MLO:  st_next = A_MHI;
            A_MHI:  st_next = A_SUM;
            A_SUM:  st_next = A_WB;
            A_WB:   st_next = (j_reg + 2'd1 < lvl_reg || lvl_reg != 2'd1) ? A_DIFF : A_IDLE;
            default: st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= A_IDLE;
            lvl_reg  <= 2'd3;
            j_reg    <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= 1'b0;
            if (st_reg == A_IDLE)
            begin
                lvl_reg <= 2'd3;
                j_reg   <= 2'd0;
            end
            else if (st_reg == A_WB)
            begin
                if (j_reg + 2'd1 < lvl_reg)
                begin
                    j_reg <= j_reg + 2'd1;
                end
                else
                begin
                    j_reg   <= 2'd0;
                    lvl_reg <= lvl_reg - 2'd1;
                    done_reg <= lvl_reg == 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == A_IDLE && start)
        begin
            s1_reg <= d1_c[DW-1];
            s2_reg <= d2_c[DW-1];
            m1_reg <= MAGW'(d1_c[DW-1] ? -d1_c : d1_c) + MAGW'(3);
            m2_reg <= MAGW'(d2_c[DW-1] ? -d2_c : d2_c) + MAGW'(3);
            v0_reg <= VW'(seg.p1);
            v3_reg <= VW'(seg.p2);
        end
        if (st_reg == A_MUL1 || st_reg == A_FIX1 || st_reg == A_MLO || st_reg == A_MHI)
        begin
            prod_reg <= mul_a_c * mul_b_c;
        end
        if (st_reg == A_FIX1)
        begin
            v1_reg <= v0_reg + sx_c;
        end
        if (st_reg == A_FIX2)
        begin
            v2_reg <= v3_reg - sx_c;
        end
        if (st_reg == A_DIFF)
        begin
            diff_reg <= b_sel_c - a_sel_c;
        end
        if (st_reg == A_MHI)
        begin
            acc_reg <= prod_reg;
        end
        if (st_reg == A_SUM)
        begin
            acc_reg <= acc_reg + (prod_reg <<< LO_W) + ROUND;
        end
        if (st_reg == A_WB)
        begin
            case (j_reg)
                2'd0:    v0_reg <= lerp_c;
                2'd1:    v1_reg <= lerp_c;
                default: v2_reg <= lerp_c;
            endcase
            if (lerp_c > POS_MAX)
                pos_reg <= POS_MAX[PW-1:0];
            else if (lerp_c < POS_MIN)
                pos_reg <= POS_MIN[PW-1:0];
            else
                pos_reg <= lerp_c[PW-1:0];
        end
    end

    assign done = done_reg;
    assign pos  = pos_reg;

endmodule

`default_nettype wire

FILE: src/periodic_spline_path_sampler_core.sv
`default_nettype none

// Channel   Direction  Payload (low bit first)
// s_axis    in         tuser: operation; tdata: point_index, point_x, point_y,
//                      point_time, query_frame, 4 pad bits
// m_axis    out        tuser: valid_res; tdata: pos_x, pos_y, id_out
// cfg       in         cfg_index 0 period_frames, 1 point_count, 2 path_id
//
// One item at a time. A write transfer goes straight to the result
// register. A query scans k points of the table (one memory read per
// cycle), then waits on the serial divider, then runs de Casteljau
// (6 lerps, 5 steps each on one multiplier per axis).
// Reset clears the FSM, configuration and output valid flag; point storage and data registers are not cleared.
// The result register frees the core: a held m_axis stall only blocks once
// the next result is ready.

module periodic_spline_path_sampler_core
    import pss_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,

    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [87:0]    s_axis_tdata,   // point_index, point_x, point_y,
                                           // point_time, query_frame, pad
    input  logic           s_axis_tuser,   // operation

    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [63:0]    m_axis_tdata,   // pos_x, pos_y, id_out
    output logic           m_axis_tuser,   // valid_res

    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    `include "periodic_spline_path_sampler_core_defines.svh"

    localparam logic [1:0] REG_PERIOD  = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_PATH_ID = 2'd2;
    localparam logic       OP_WRITE    = 1'b0;
    localparam logic       OP_QUERY    = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_START  = 6'b001000,
        S_EVAL   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [FW-1:0]  period_reg;
    logic [4:0]     count_reg;
    logic [IDW-1:0] path_id_reg;

    // input fields
    logic                 s_accept;
    logic [3:0]           in_index;
    pss_point_t           in_point;
    logic [FW-1:0]        in_frame;

    // scan
    logic [CNT_W-1:0] n_reg, n_eff_c;
    logic [CNT_W-1:0] issue_reg, data_idx_reg;
    logic             pend_reg;
    logic [FW-1:0]    frame_reg;
    pss_point_t       e0_reg, e1_reg;
    pss_point_t       q0_reg, q1_reg, q2_reg, q3_reg;
    logic             first_reg, last_reg;
    logic signed [SW-1:0] num_reg, den_reg;

    // memory
    logic             mem_wr_en, mem_rd_en;
    pss_point_t       mem_rd;

    // segment test
    logic [TW-1:0]    t1_c, t2_c;
    logic [TW:0]      f_c, per_c, f_adj_c, t2a_c;
    logic             hit_c, test_c;
    logic signed [SW-1:0] num_c, den_c;

    // evaluation
    logic             div_start, div_q_valid;
    logic signed [RW-1:0] div_quot;
    pss_axis_in_t     ax_in_x, ax_in_y;
    logic             ax_done_x, ax_done_y;
    logic signed [PW-1:0] ax_pos_x, ax_pos_y;

    // result and output register
    logic                 res_valid_reg;
    logic signed [PW-1:0] res_x_reg, res_y_reg;
    logic                 out_load;
    logic                 out_valid_reg;
    logic                 out_flag_reg;
    logic [PW-1:0]        out_x_reg, out_y_reg;
    logic [IDW-1:0]       out_id_reg;

    assign s_axis_tready = state_reg == S_IDLE;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_index      = s_axis_tdata[3:0];
    assign in_point.x    = s_axis_tdata[27:4];
    assign in_point.y    = s_axis_tdata[51:28];
    assign in_point.t    = s_axis_tdata[71:52];
    assign in_frame      = s_axis_tdata[83:72];

    assign n_eff_c = (32'(count_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(count_reg);

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= FW'(256);
            count_reg   <= '0;
            path_id_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PERIOD:  period_reg  <= cfg_data[FW-1:0];
                REG_COUNT:   count_reg   <= cfg_data[4:0];
                REG_PATH_ID: path_id_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ---- point storage ----
    // Writes go straight in on the accepting edge; reads run only during
    // a query, so the two never meet on one entry.
    assign mem_wr_en = s_accept && s_axis_tuser == OP_WRITE && 32'(in_index) < MAX_POINTS;
    assign mem_rd_en = state_reg == S_SCAN && issue_reg < n_reg;

    pss_point_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (ADDR_W'(in_index)),
        .wr_data (in_point),
        .rd_en   (mem_rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (mem_rd)
    );

    // ---- segment test: previous point against the one just read ----
    always_comb
    begin
        t1_c  = e0_reg.t;
        t2_c  = mem_rd.t;
        f_c   = (TW+1)'(frame_reg) << FRAC_BITS;
        per_c = (TW+1)'(period_reg) << FRAC_BITS;
        if (t1_c > t2_c)
        begin
            // segment wraps past the period end
            hit_c   = !(f_c <= (TW+1)'(t1_c) && f_c >= (TW+1)'(t2_c));
            f_adj_c = (f_c < (TW+1)'(t2_c)) ? f_c + per_c : f_c;
            t2a_c   = (TW+1)'(t2_c) + per_c;
        end
        else
        begin
            hit_c   = f_c >= (TW+1)'(t1_c) && f_c < (TW+1)'(t2_c);
            f_adj_c = f_c;
            t2a_c   = (TW+1)'(t2_c);
        end
        num_c  = $signed(SW'(f_adj_c)) - $signed(SW'(t1_c));
        den_c  = $signed(SW'(t2a_c)) - $signed(SW'(t1_c));
        test_c = state_reg == S_SCAN && pend_reg && data_idx_reg != '0;
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_accept)
                begin
                    if (s_axis_tuser == OP_QUERY && n_eff_c >= CNT_W'(2))
                        state_next = S_SCAN;
                    else
                        state_next = S_FINISH;
                end
            S_SCAN:
                if (test_c)
                begin
                    if (hit_c)
                    begin
                        if (den_c == '0)
                            state_next = S_FINISH;
                        else if (data_idx_reg == n_reg - CNT_W'(1))
                            state_next = S_START;
                        else
                            state_next = S_FETCH;
                    end
                    else if (data_idx_reg == n_reg - CNT_W'(1))
                    begin
                        state_next = S_FINISH;
                    end
                end
            S_FETCH:  state_next = S_START;
            S_START:  state_next = S_EVAL;
            S_EVAL:   if (ax_done_x) state_next = S_FINISH;
            S_FINISH: if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign div_start = state_reg == S_START;
    assign out_load  = state_reg == S_FINISH && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            data_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_accept)
            begin
                issue_reg    <= '0;
                data_idx_reg <= '0;
                pend_reg     <= 1'b0;
            end
            else
            begin
                pend_reg <= mem_rd_en;
                if (mem_rd_en)
                    issue_reg <= issue_reg + CNT_W'(1);
                if (pend_reg)
                    data_idx_reg <= data_idx_reg + CNT_W'(1);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            frame_reg     <= in_frame;
            n_reg         <= n_eff_c;
            res_valid_reg <= 1'b0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
        end
        if (state_reg == S_SCAN && pend_reg)
        begin
            e0_reg <= mem_rd;
            e1_reg <= e0_reg;
        end
        if (test_c && hit_c)
        begin
            res_valid_reg <= 1'b1;
            q0_reg    <= e1_reg;
            q1_reg    <= e0_reg;
            q2_reg    <= mem_rd;
            first_reg <= data_idx_reg == CNT_W'(1);
            last_reg  <= data_idx_reg == n_reg - CNT_W'(1);
            num_reg   <= num_c;
            den_reg   <= den_c;
        end
        if (state_reg == S_FETCH)
        begin
            q3_reg <= mem_rd;
        end
        if (state_reg == S_EVAL && ax_done_x)
        begin
            res_x_reg <= ax_pos_x;
            res_y_reg <= ax_pos_y;
        end
        if (out_load)
        begin
            out_flag_reg <= res_valid_reg;
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_y_reg;
            out_id_reg   <= path_id_reg;
        end
    end

    // ---- ratio divider and per-axis evaluators ----
    pss_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .q_valid (div_q_valid),
        .quot    (div_quot)
    );

    assign ax_in_x = '{p0: q0_reg.x, p1: q1_reg.x, p2: q2_reg.x, p3: q3_reg.x,
                       first: first_reg, last: last_reg};
    assign ax_in_y = '{p0: q0_reg.y, p1: q1_reg.y, p2: q2_reg.y, p3: q3_reg.y,
                       first: first_reg, last: last_reg};

    pss_axis u_axis_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .seg     (ax_in_x),
        .r_valid (div_q_valid),
        .r       (div_quot),
        .done    (ax_done_x),
        .pos     (ax_pos_x)
    );

    pss_axis u_axis_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .seg     (ax_in_y),
        .r_valid (div_q_valid),
        .r       (div_quot),
        .done    (ax_done_y),
        .pos     (ax_pos_y)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tdata  = {out_id_reg, out_y_reg, out_x_reg};

    `PSS_ASSERT_NOW(a_scan_bound, state_reg == S_SCAN, data_idx_reg < n_reg, "scan past last point")
    `PSS_ASSERT_NOW(a_out_free, out_load, !out_valid_reg || m_axis_tready, "result overwritten")
    `PSS_ASSERT_NOW(a_lanes_sync, ax_done_x || ax_done_y, ax_done_x && ax_done_y, "axes out of step")
    `PSS_ASSERT_NOW(a_ratio_ready, state_reg == S_EVAL && ax_done_x, div_q_valid, "eval before ratio")

endmodule

`default_nettype wire
